// ===== rtl/jsu_pkg.sv =====
// shared types and constants for the json string unescaper
package jsu_pkg;

   // job queue between the decoder and the byte serialiser
   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   // at most four output bytes per decoded item
   localparam int JobBytes = 4;
   localparam int JobIdxWidth = $clog2(JobBytes);

   // one decoded item: its output bytes, first byte in slot zero
   typedef struct packed {
      logic [JobBytes-1:0][7:0] data;
      logic [JobIdxWidth-1:0]   last_idx;
   } job_type;

endpackage

// ===== rtl/jsu_front.sv =====
// decoder front end: escape state machine and utf-8 encoding of each input beat
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [7:0]       req_byte_in,
   input  logic             req_end_of_string,
   input  logic             q_full,
   output logic             q_push,
   output jsu_pkg::job_type q_job
);
   import jsu_pkg::*;

   localparam logic [7:0] CharBackslash = 8'h5c;
   localparam logic [7:0] CharN         = 8'h6e;
   localparam logic [7:0] CharU         = 8'h75;
   localparam logic [7:0] CharLineFeed  = 8'h0a;
   localparam logic [15:0] HighFirst    = 16'hd800;
   localparam logic [15:0] HighLast     = 16'hdbff;
   localparam logic [15:0] LowFirst     = 16'hdc00;
   localparam logic [15:0] LowLast      = 16'hdfff;
   localparam logic [20:0] PlaneOne     = 21'h010000;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESC,
      PH_HEX1,
      PH_WANT_BS,
      PH_WANT_U,
      PH_HEX2,
      PH_HALT
   } phase_type;

   // hex digit value, anything else counts as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
      return v;
   endfunction

   // single byte job
   function automatic job_type one_byte(input logic [7:0] b);
      job_type j;
      j = '0;
      j.data[0] = b;
      j.last_idx = JobIdxWidth'(0);
      return j;
   endfunction

   // utf-8 of one bmp code unit
   function automatic job_type encode_unit(input logic [15:0] u);
      job_type j;
      j = '0;
      if (u < 16'h0080) begin
         j.data[0] = u[7:0];
         j.last_idx = JobIdxWidth'(0);
      end else if (u < 16'h0800) begin
         j.data[0] = {3'b110, u[10:6]};
         j.data[1] = {2'b10, u[5:0]};
         j.last_idx = JobIdxWidth'(1);
      end else begin
         j.data[0] = {4'b1110, u[15:12]};
         j.data[1] = {2'b10, u[11:6]};
         j.data[2] = {2'b10, u[5:0]};
         j.last_idx = JobIdxWidth'(2);
      end
      return j;
   endfunction

   // utf-8 of a supplementary code point
   function automatic job_type encode_pair(input logic [20:0] cp);
      job_type j;
      j = '0;
      j.data[0] = {5'b11110, cp[20:18]};
      j.data[1] = {2'b10, cp[17:12]};
      j.data[2] = {2'b10, cp[11:6]};
      j.data[3] = {2'b10, cp[5:0]};
      j.last_idx = JobIdxWidth'(3);
      return j;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] high_ff, high_in;
   logic        accept;
   logic        emit;
   logic [15:0] unit;
   logic [20:0] cp;
   job_type     job;

   assign accept = req_push && !q_full;
   assign unit   = {accum_ff[11:0], hex_value(req_byte_in)};
   assign cp     = PlaneOne + {1'b0, high_ff[9:0], unit[9:0]};

   // next state and job for the current beat
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      high_in  = high_ff;
      emit     = 1'b0;
      job      = one_byte(req_byte_in);
      unique case (phase_ff)
         PH_NORMAL: begin
            if (req_byte_in == CharBackslash) phase_in = PH_ESC;
            else emit = 1'b1;
         end
         PH_ESC: begin
            phase_in = PH_NORMAL;
            if (req_byte_in == CharBackslash) begin
               emit = 1'b1;
               job  = one_byte(CharBackslash);
            end else if (req_byte_in == CharN) begin
               emit = 1'b1;
               job  = one_byte(CharLineFeed);
            end else if (req_byte_in == CharU) begin
               phase_in = PH_HEX1;
               accum_in = '0;
               count_in = '0;
            end
         end
         PH_HEX1: begin
            if (count_ff == 2'd3) begin
               count_in = '0;
               accum_in = '0;
               if (unit >= HighFirst && unit <= HighLast) begin
                  high_in  = unit;
                  phase_in = PH_WANT_BS;
               end else begin
                  emit     = 1'b1;
                  job      = encode_unit(unit);
                  phase_in = PH_NORMAL;
               end
            end else begin
               accum_in = unit;
               count_in = count_ff + 2'd1;
            end
         end
         PH_WANT_BS: begin
            phase_in = (req_byte_in == CharBackslash) ? PH_WANT_U : PH_HALT;
         end
         PH_WANT_U: begin
            if (req_byte_in == CharU) begin
               phase_in = PH_HEX2;
               accum_in = '0;
               count_in = '0;
            end else begin
               phase_in = PH_HALT;
            end
         end
         PH_HEX2: begin
            if (count_ff == 2'd3) begin
               count_in = '0;
               accum_in = '0;
               if (unit >= LowFirst && unit <= LowLast) begin
                  emit     = 1'b1;
                  job      = encode_pair(cp);
                  high_in  = '0;
                  phase_in = PH_NORMAL;
               end else begin
                  phase_in = PH_HALT;
               end
            end else begin
               accum_in = unit;
               count_in = count_ff + 2'd1;
            end
         end
         default: phase_in = PH_HALT;
      endcase
      // end of string returns everything to reset values
      if (req_end_of_string) begin
         phase_in = PH_NORMAL;
         accum_in = '0;
         count_in = '0;
         high_in  = '0;
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         accum_ff <= '0;
         count_ff <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

   assign q_push = accept && emit;
   assign q_job  = job;

endmodule

// ===== rtl/jsu_queue.sv =====
// short job queue between decoder and serialiser
module jsu_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   input  logic             pop,
   output jsu_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import jsu_pkg::*;

   job_type                    entries_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full    = (count_ff == QueueCountWidth'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 :
                     wr_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 :
                     rd_ptr_ff + QueuePtrWidth'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + QueueCountWidth'(1);
      else if (do_pop && !do_push) count_in = count_ff - QueueCountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_job;
   end

   assign head_job = entries_ff[rd_ptr_ff];

endmodule

// ===== rtl/jsu_back.sv =====
// serialiser back end: walks the head job one byte per beat into the output register
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::job_type head_job,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_last_of_run
);
   import jsu_pkg::*;

   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   logic                   last_ff, last_in;
   logic [JobIdxWidth-1:0] idx_ff, idx_in;
   logic                   taken;
   logic                   load;
   logic                   at_last;

   assign taken   = rsp_pop && valid_ff;
   assign load    = !q_empty && (!valid_ff || taken);
   assign at_last = (idx_ff == head_job.last_idx);
   assign q_pop   = load && at_last;

   // next output beat
   always_comb begin
      valid_in = valid_ff && !taken;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_job.data[idx_ff];
         last_in  = at_last;
         idx_in   = at_last ? '0 : idx_ff + JobIdxWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_byte_out    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== rtl/json_string_unescape_utf8_core.sv =====
// Path: the decoder writes the job of an accepted byte into the job queue, and the
// serialiser moves the head job's bytes into the output register. Throughput: one
// input beat per cycle while the queue is not full; a four-byte surrogate pair leaves
// the output byte by byte as a four-job queue absorbs input. Reset (synchronous,
// active high) clears the escape state, the job queue and the output register.
module json_string_unescape_utf8_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_string,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_last_of_run
);
   import jsu_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type head_job;

   assign req_full = q_full;

   // decoder
   jsu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   // job queue
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // serialiser
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== rtl/jsu_checker.sv =====
// port-level checks for the json string unescaper
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_last_of_run
);

   // nothing is waiting straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("output or queue not empty after reset");

   // a waiting beat holds until it is taken
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_byte_out) && $stable(rsp_last_of_run)))
      else $error("stalled output beat changed");

   // a full queue always has a beat presented at the output
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("queue full while output register empty");

   // with the output drained and no input, nothing can appear
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !req_full && !req_push && $past(rsp_empty) && $past(!req_push)
       && !$past(reset)) |=> rsp_empty)
      else $error("output beat without a source");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_byte_out    (rsp_byte_out),
   .rsp_last_of_run (rsp_last_of_run)
);

// ===== bench/json_string_unescape_utf8_core_tb.sv =====
// self-checking testbench for the json string unescaper with utf-8 output
module json_string_unescape_utf8_core_tb;
   import jsu_pkg::*;

   // escape decoder phases, as the bench tracks them
   typedef enum logic [2:0] {
      PhNormal,
      PhEscape,
      PhUnitDigits,
      PhWantBackslash,
      PhWantU,
      PhLowDigits,
      PhHalted
   } esc_phase_type;

   // one output beat as the bench expects it
   typedef struct {
      logic [7:0] data;
      logic       last;
   } utf8_beat_type;

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharN = 8'h6E;
   localparam logic [7:0] CharU = 8'h75;
   localparam logic [7:0] CharLineFeed = 8'h0A;
   localparam logic [15:0] HighFirst = 16'hD800;
   localparam logic [15:0] HighLast = 16'hDBFF;
   localparam logic [15:0] LowFirst = 16'hDC00;
   localparam logic [15:0] LowLast = 16'hDFFF;
   localparam int IdleLimit = 4000;
   localparam int TailCycles = 20;
   localparam int RandomBytes = 150;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_byte_in = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_byte_out;
   logic       rsp_last_of_run;

   // bench copy of the decoder state
   esc_phase_type esc_phase = PhNormal;
   logic [15:0]   unit_accum = '0;
   logic [1:0]    digits_seen = '0;
   logic [15:0]   held_high = '0;

   utf8_beat_type pending_utf8[$];
   logic [7:0]    draft[$];
   int            mismatches = 0;
   int            bytes_sent = 0;
   int            idle_cycles = 0;
   int            pop_hold = 0;
   logic          pop_level = 1'b0;
   bit            steady = 1'b0;

   json_string_unescape_utf8_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_byte_in(req_byte_in),
      .req_end_of_string(req_end_of_string),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_byte_out(rsp_byte_out),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #1 clock = ~clock;

   // gap lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'h0;
   endfunction

   // shift one digit in; high when the fourth digit closes a code unit
   function automatic bit shift_digit(input logic [7:0] c);
      unit_accum = {unit_accum[11:0], digit_value(c)};
      if (digits_seen == 2'd3) begin
         digits_seen = 2'd0;
         return 1'b1;
      end
      digits_seen = digits_seen + 2'd1;
      return 1'b0;
   endfunction

   function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] seq);
      seq = '0;
      if (cp < 21'h80) begin
         seq[0] = cp[7:0];
         return 1;
      end
      if (cp < 21'h800) begin
         seq[0] = {3'b110, cp[10:6]};
         seq[1] = {2'b10, cp[5:0]};
         return 2;
      end
      if (cp < 21'h10000) begin
         seq[0] = {4'b1110, cp[15:12]};
         seq[1] = {2'b10, cp[11:6]};
         seq[2] = {2'b10, cp[5:0]};
         return 3;
      end
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      return 4;
   endfunction

   // advance the bench decoder by one accepted byte and queue its output bytes
   function automatic void predict_unescape(input logic [7:0] c, input logic eos);
      logic [3:0][7:0] seq;
      logic [15:0]     unit;
      logic [20:0]     cp;
      int              count;
      count = 0;
      seq = '0;
      case (esc_phase)
         PhNormal: begin
            if (c == CharBackslash) esc_phase = PhEscape;
            else begin
               seq[0] = c;
               count = 1;
            end
         end
         PhEscape: begin
            esc_phase = PhNormal;
            if (c == CharBackslash) begin
               seq[0] = CharBackslash;
               count = 1;
            end else if (c == CharN) begin
               seq[0] = CharLineFeed;
               count = 1;
            end else if (c == CharU) begin
               esc_phase = PhUnitDigits;
               unit_accum = '0;
               digits_seen = '0;
            end
         end
         PhUnitDigits: begin
            if (shift_digit(c)) begin
               unit = unit_accum;
               unit_accum = '0;
               if (unit >= HighFirst && unit <= HighLast) begin
                  held_high = unit;
                  esc_phase = PhWantBackslash;
               end else begin
                  count = utf8_encode({5'd0, unit}, seq);
                  esc_phase = PhNormal;
               end
            end
         end
         PhWantBackslash: esc_phase = (c == CharBackslash) ? PhWantU : PhHalted;
         PhWantU: begin
            if (c == CharU) begin
               esc_phase = PhLowDigits;
               unit_accum = '0;
               digits_seen = '0;
            end else esc_phase = PhHalted;
         end
         PhLowDigits: begin
            if (shift_digit(c)) begin
               unit = unit_accum;
               unit_accum = '0;
               if (unit >= LowFirst && unit <= LowLast) begin
                  cp = 21'h10000 + {1'b0, held_high[9:0], 10'd0} + {11'd0, unit[9:0]};
                  count = utf8_encode(cp, seq);
                  held_high = '0;
                  esc_phase = PhNormal;
               end else esc_phase = PhHalted;
            end
         end
         default: esc_phase = PhHalted;
      endcase
      for (int k = 0; k < count; k++) begin
         pending_utf8.push_back('{data: seq[k], last: (k == count - 1)});
      end
      if (eos) begin
         esc_phase = PhNormal;
         unit_accum = '0;
         digits_seen = '0;
         held_high = '0;
      end
   endfunction

   // send one input beat after a random gap; push stays high afterwards
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) begin
            req_byte_in = 8'($urandom);
            req_end_of_string = 1'($urandom);
            @(negedge clock);
         end
      end
      req_push = 1'b1;
      req_byte_in = b;
      req_end_of_string = eos;
      do @(posedge clock); while (req_full);
      predict_unescape(b, eos);
      bytes_sent++;
   endtask

   task automatic stop_pushing();
      @(negedge clock);
      req_push = 1'b0;
   endtask

   // hold the input side until every expected byte has drained
   task automatic drain_output();
      stop_pushing();
      while (pending_utf8.size() != 0) @(posedge clock);
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], close && (i == s.len() - 1));
      end
   endtask

   // send the draft string, end of string on its last byte
   task automatic send_draft();
      for (int i = 0; i < draft.size(); i++) begin
         send_byte(draft[i], i == draft.size() - 1);
      end
      draft.delete();
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) return 8'("0" + nib);
      return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
   endfunction

   // append a \u escape; now and then one digit is not hex at all
   function automatic void add_unit(input logic [15:0] unit);
      draft.push_back(CharBackslash);
      draft.push_back(CharU);
      for (int i = 3; i >= 0; i--) begin
         if ($urandom_range(0, 19) == 0) draft.push_back(8'(8'h67 + $urandom_range(0, 19)));
         else draft.push_back(hex_char(unit[i*4 +: 4]));
      end
   endfunction

   function automatic void add_token();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: draft.push_back(8'($urandom));
         3: begin
            draft.push_back(CharBackslash);
            case ($urandom_range(0, 2))
               0: draft.push_back(CharBackslash);
               1: draft.push_back(CharN);
               default: draft.push_back(8'($urandom));
            endcase
         end
         4: add_unit(16'($urandom_range(0, 16'h7F)));
         5: add_unit(16'($urandom_range(16'h80, 16'h7FF)));
         6: add_unit(16'($urandom_range(16'h800, 16'hFFFF)));
         7, 8: begin
            add_unit(16'($urandom_range(HighFirst, HighLast)));
            case ($urandom_range(0, 9))
               0: draft.push_back(8'($urandom));
               1: begin
                  draft.push_back(CharBackslash);
                  draft.push_back(8'($urandom));
               end
               2: add_unit(16'($urandom));
               default: add_unit(16'($urandom_range(LowFirst, LowLast)));
            endcase
         end
         default: add_unit(16'($urandom_range(LowFirst, LowLast)));
      endcase
   endfunction

   // plain bytes at the extremes of the byte range
   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // backslash, line feed, a dropped escape, and a string ending on a backslash
   task automatic test_simple_escapes();
      send_text("\\\\\\n\\q", 1'b0);
      send_text("a\\", 1'b1);
   endtask

   // code units at each encoding boundary, a lone low surrogate, non-hex digits
   task automatic test_code_units();
      send_text("\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF", 1'b0);
      send_text("\\udc00\\uz1G", 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // valid pairs, each way of breaking a pair, and a string ending mid-escape
   task automatic test_surrogates();
      send_text("\\uD800\\uDC00\\udbff\\udfff", 1'b1);
      send_text("\\uD800xab", 1'b1);
      send_text("\\uDBFF\\q", 1'b1);
      send_text("\\uD801\\u0041z", 1'b1);
      send_text("\\u12", 1'b1);
   endtask

   // random strings: mostly well formed, some noise, some cut short
   task automatic test_random_strings();
      int start;
      int strings;
      int len;
      start = bytes_sent;
      strings = 0;
      while (bytes_sent - start < RandomBytes) begin
         steady = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom), (i == len - 1) || ($urandom_range(0, 3) == 0));
            end
         end else begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) add_token();
            if ($urandom_range(0, 7) == 0) begin
               len = $urandom_range(1, draft.size());
               while (draft.size() > len) void'(draft.pop_back());
            end
            send_draft();
         end
         strings++;
         if (strings % 10 == 0) drain_output();
      end
      steady = 1'b0;
   endtask

   // result side: pop with random stalls
   always @(negedge clock) begin : pop_driver
      if (pop_hold == 0) begin
         if (steady || $urandom_range(0, 3) != 0) begin
            pop_level = 1'b1;
            pop_hold = $urandom_range(1, 12);
         end else begin
            pop_level = 1'b0;
            pop_hold = pick_gap() + 1;
         end
      end
      pop_hold = pop_hold - 1;
      rsp_pop <= pop_level;
   end

   // compare each popped beat with the oldest expected byte
   always @(posedge clock) begin : beat_check
      utf8_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_utf8.size() == 0) begin
            $error("unexpected beat: byte_out=%h last_of_run=%b", rsp_byte_out,
                   rsp_last_of_run);
            mismatches++;
         end else begin
            want = pending_utf8.pop_front();
            if (rsp_byte_out !== want.data) begin
               $error("byte_out: expected %h, got %h", want.data, rsp_byte_out);
               mismatches++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, rsp_last_of_run);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("json_string_unescape_utf8_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_plain_bytes();
      test_simple_escapes();
      test_code_units();
      test_surrogates();
      test_random_strings();
      drain_output();
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && pending_utf8.size() == 0) begin
         $display("json_string_unescape_utf8_core regression: pass");
      end else begin
         $display("json_string_unescape_utf8_core regression: fail");
      end
      $finish;
   end

endmodule
